// File: sv/pwa_pkg.sv
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared widths, register indexes and control types of the power window
// accumulator.
// ----------------------------------------------------------------------------
package pwa_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int GAIN_W     = 16;
    localparam int OP_W       = 18;     // multiplier operand width
    localparam int PROD_W     = 2 * OP_W;
    localparam int FRAC_W     = 8;      // Q8.8 fraction bits
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WINDOW_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 2'd2;

    localparam logic [SAMPLE_W-1:0] ZERO_OFFSET_RST = 10'd512;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 16'd256;

    typedef enum logic [1:0] {
        ACC_SEL_VSQ = 2'd0,
        ACC_SEL_ISQ = 2'd1,
        ACC_SEL_PWR = 2'd2
    } t_acc_sel;

    typedef struct packed {
        logic     en;     // add product into selected accumulator
        t_acc_sel sel;
        logic     clr;    // end of window: clear all three
    } t_acc_ctrl;

endpackage

// File: sv/pwa_mul.sv
// ----------------------------------------------------------------------------
// pwa_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module pwa_mul (
    input  logic                      i_clk,
    input  logic [pwa_pkg::OP_W-1:0]  i_a,
    input  logic [pwa_pkg::OP_W-1:0]  i_b,
    output logic [pwa_pkg::PROD_W-1:0] o_p
);

    logic [pwa_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= pwa_pkg::PROD_W'(i_a) * pwa_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: sv/pwa_acc.sv
// ----------------------------------------------------------------------------
// pwa_acc
// Three saturating accumulators sharing one adder.
// ----------------------------------------------------------------------------
module pwa_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pwa_pkg::t_acc_ctrl          i_ctrl,
    input  logic [pwa_pkg::PROD_W-1:0]  i_prod,
    output logic [pwa_pkg::ACC_W-1:0]   o_vsq,
    output logic [pwa_pkg::ACC_W-1:0]   o_isq,
    output logic [pwa_pkg::ACC_W-1:0]   o_pwr,
    output logic [pwa_pkg::ACC_W-1:0]   o_sum    // saturated sum this cycle
);

    logic [pwa_pkg::ACC_W-1:0] r_vsq, r_isq, r_pwr;
    logic [pwa_pkg::ACC_W-1:0] w_opnd;
    logic [pwa_pkg::ACC_W:0]   w_raw;

    always_comb begin
        unique case (i_ctrl.sel)
            pwa_pkg::ACC_SEL_VSQ: w_opnd = r_vsq;
            pwa_pkg::ACC_SEL_ISQ: w_opnd = r_isq;
            pwa_pkg::ACC_SEL_PWR: w_opnd = r_pwr;
            default:              w_opnd = r_pwr;
        endcase
        w_raw = {1'b0, w_opnd} + (pwa_pkg::ACC_W + 1)'(i_prod);
        // stick at all ones on overflow
        o_sum = w_raw[pwa_pkg::ACC_W] ? {pwa_pkg::ACC_W{1'b1}}
                                      : w_raw[pwa_pkg::ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_vsq <= '0;
            r_isq <= '0;
            r_pwr <= '0;
        end else if (i_ctrl.en) begin
            case (i_ctrl.sel)
                pwa_pkg::ACC_SEL_VSQ: r_vsq <= o_sum;
                pwa_pkg::ACC_SEL_ISQ: r_isq <= o_sum;
                default:              r_pwr <= o_sum;
            endcase
        end
    end

    assign o_vsq = r_vsq;
    assign o_isq = r_isq;
    assign o_pwr = r_pwr;

endmodule

// File: sv/power_window_accumulator.sv
// ----------------------------------------------------------------------------
// power_window_accumulator
// Windowed sums of V^2, I^2 and V*I from paired converter samples.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one voltage/current code pair per item.
//   Each pair is taken as |code - zero_offset|, scaled by its Q8.8 gain,
//   and V^2, I^2 and V*I are added to saturating 48-bit sums.
//   After WINDOW items the master stream (o_m_*) presents the three sums as
//   one item and the sums and sample count restart from zero.
//   Config: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
//   (0 zero_offset, 1 voltage_gain, 2 current_gain, 3 ignored).
// Timing:
//   Each item is accepted in the idle step and then runs six sequencer steps:
//   five on the one shared 18x18 multiplier (two gain scalings, three products)
//   and a final add, the shared saturating adder working on the registered product.
//   o_s_tready is high only in the idle step, so a new item is taken only after
//   the last has left the final step, where a window result is registered.
// Reset:
//   Synchronous active-low; registers return to 512/256/256, sums and
//   count to zero, output empty.
// Stall:
//   The result sits in an output register; further items are accepted
//   meanwhile. Only if the next window completes while that result still
//   waits does the sequencer hold in its final step.
// ----------------------------------------------------------------------------
module power_window_accumulator #(
    parameter int WINDOW = pwa_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [pwa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pwa_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [23:0]                         i_s_tdata,  // voltage_sample, current_sample, pad
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [3*pwa_pkg::ACC_W-1:0]         o_m_tdata   // voltage_square_sum,
                                                            // current_square_sum, power_sum
);

    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

    // one-hot sequencer
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MV   = 7'b0000010,   // mag_v * gain_v
        S_MI   = 7'b0000100,   // mag_i * gain_i
        S_MVV  = 7'b0001000,   // v * v
        S_MII  = 7'b0010000,   // i * i, add v*v
        S_MVI  = 7'b0100000,   // v * i, add i*i
        S_ACC  = 7'b1000000    // add v*i, window check
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [pwa_pkg::SAMPLE_W-1:0] r_zero_off;
    logic [pwa_pkg::GAIN_W-1:0]   r_gain_v, r_gain_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_off <= pwa_pkg::ZERO_OFFSET_RST;
            r_gain_v   <= pwa_pkg::GAIN_RST;
            r_gain_i   <= pwa_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwa_pkg::REG_ZERO_OFFSET:
                    r_zero_off <= i_cfg_wdata[pwa_pkg::SAMPLE_W-1:0];
                pwa_pkg::REG_VOLTAGE_GAIN: r_gain_v <= i_cfg_wdata;
                pwa_pkg::REG_CURRENT_GAIN: r_gain_i <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input capture: magnitudes about the zero offset
    logic                         w_in_acc;
    logic [pwa_pkg::SAMPLE_W-1:0] w_smp_v, w_smp_i, w_mag_v, w_mag_i;
    logic [pwa_pkg::SAMPLE_W-1:0] r_mag_v, r_mag_i;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_smp_v    = i_s_tdata[9:0];
    assign w_smp_i    = i_s_tdata[19:10];
    assign w_mag_v    = (w_smp_v >= r_zero_off) ? w_smp_v - r_zero_off
                                                : r_zero_off - w_smp_v;
    assign w_mag_i    = (w_smp_i >= r_zero_off) ? w_smp_i - r_zero_off
                                                : r_zero_off - w_smp_i;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mag_v <= w_mag_v;
            r_mag_i <= w_mag_i;
        end
    end

    // shared multiplier and operand select
    logic [pwa_pkg::OP_W-1:0]   w_op_a, w_op_b;
    logic [pwa_pkg::PROD_W-1:0] w_prod;
    logic [pwa_pkg::OP_W-1:0]   r_v, r_i;   // scaled instantaneous values

    always_comb begin
        unique case (r_state) inside
            S_MV: begin
                w_op_a = pwa_pkg::OP_W'(r_mag_v);
                w_op_b = pwa_pkg::OP_W'(r_gain_v);
            end
            S_MI: begin
                w_op_a = pwa_pkg::OP_W'(r_mag_i);
                w_op_b = pwa_pkg::OP_W'(r_gain_i);
            end
            S_MVV: begin
                w_op_a = r_v;
                w_op_b = r_v;
            end
            S_MII: begin
                w_op_a = r_i;
                w_op_b = r_i;
            end
            // v*i kept on the multiplier while the final step holds
            S_MVI, S_ACC: begin
                w_op_a = r_v;
                w_op_b = r_i;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    pwa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_p   (w_prod)
    );

    // Q8.8 truncation of the scaling products
    always_ff @(posedge i_clk) begin
        if (r_state == S_MI)  r_v <= w_prod[pwa_pkg::FRAC_W +: pwa_pkg::OP_W];
        if (r_state == S_MVV) r_i <= w_prod[pwa_pkg::FRAC_W +: pwa_pkg::OP_W];
    end

    // window control
    logic [CNT_W-1:0]            r_cnt;
    logic                        w_last, w_stall, w_emit;
    pwa_pkg::t_acc_ctrl          w_ctrl;
    logic [pwa_pkg::ACC_W-1:0]   w_vsq, w_isq, w_pwr, w_sum;
    logic                        r_out_valid;
    logic [3*pwa_pkg::ACC_W-1:0] r_out_data;

    assign w_last  = (r_cnt == CNT_LAST);
    // hold final step while the previous window result is still waiting
    assign w_stall = (r_state == S_ACC) && w_last && r_out_valid && !i_m_tready;
    assign w_emit  = (r_state == S_ACC) && w_last && !w_stall;

    always_comb begin
        w_ctrl.en  = 1'b0;
        w_ctrl.sel = pwa_pkg::ACC_SEL_PWR;
        w_ctrl.clr = w_emit;
        unique case (r_state)
            S_MII: begin
                w_ctrl.en  = 1'b1;
                w_ctrl.sel = pwa_pkg::ACC_SEL_VSQ;
            end
            S_MVI: begin
                w_ctrl.en  = 1'b1;
                w_ctrl.sel = pwa_pkg::ACC_SEL_ISQ;
            end
            S_ACC: begin
                w_ctrl.en  = !w_stall;
                w_ctrl.sel = pwa_pkg::ACC_SEL_PWR;
            end
            default: ;
        endcase
    end

    pwa_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_prod  (w_prod),
        .o_vsq   (w_vsq),
        .o_isq   (w_isq),
        .o_pwr   (w_pwr),
        .o_sum   (w_sum)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_MV;
            S_MV:    n_state = S_MI;
            S_MI:    n_state = S_MVV;
            S_MVV:   n_state = S_MII;
            S_MII:   n_state = S_MVI;
            S_MVI:   n_state = S_ACC;
            S_ACC:   if (!w_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit)
                r_cnt <= '0;
            else if (r_state == S_ACC && !w_stall)
                r_cnt <= r_cnt + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_emit)
            r_out_valid <= 1'b1;
        else if (i_m_tready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) r_out_data <= {w_sum, w_isq, w_vsq};
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("sample count beyond window");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_MV)
        else $error("accepted item did not start the sequence");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (w_vsq == '0 && w_isq == '0 && w_pwr == '0 && r_cnt == '0))
        else $error("window end did not clear sums");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_ACC))
        else $error("result raised outside final step");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for power_window_accumulator. Sample pairs stream in
// on the slave side and window sums come out on the master side; a local
// model of the datapath works out each window's three sums as pairs are
// accepted, and every result item is checked field by field in order.
// A short directed run at reset settings comes first, then phases of
// random pairs under changing offset and gain settings, extremes included.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = pwa_pkg::WINDOW_DEF;
    localparam int DRAIN_CYCLES = 12;   // lets an item still in the sequencer finish
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 120;
    localparam int DIRECTED_N   = 24;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [pwa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [pwa_pkg::ACC_W-1:0] SUM_MAX = '1;

    // packed MSB first, so the struct lines up with o_m_tdata directly
    typedef struct packed {
        logic [pwa_pkg::ACC_W-1:0] pwr;
        logic [pwa_pkg::ACC_W-1:0] isq;
        logic [pwa_pkg::ACC_W-1:0] vsq;
    } t_window_sums;

    typedef struct packed {
        logic [pwa_pkg::SAMPLE_W-1:0] vs;
        logic [pwa_pkg::SAMPLE_W-1:0] cs;
        logic                         has_sums;  // sums below typed in by hand
        t_window_sums                 sums;
    } t_pair_row;

    // Directed pairs at reset settings (offset 512, unity gains).
    // First window: one pair at each rail, the rest sitting at the offset,
    // so the sums are 512^2 + 511^2 on both squares and 2*512*511 on power.
    // The rows after that start the next window and go to the model.
    localparam t_pair_row DIRECTED_ROWS [DIRECTED_N] = '{
        '{10'd0,    10'd1023, 1'b0, '0},
        '{10'd1023, 10'd0,    1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b0, '0},
        '{10'd512,  10'd512,  1'b1, '{48'd523264, 48'd523265, 48'd523265}},
        '{10'd1,    10'd1022, 1'b0, '0},
        '{10'd511,  10'd513,  1'b0, '0},
        '{10'd513,  10'd511,  1'b0, '0},
        '{10'd1023, 10'd1023, 1'b0, '0},
        '{10'd0,    10'd0,    1'b0, '0},
        '{10'd341,  10'd682,  1'b0, '0},
        '{10'd682,  10'd341,  1'b0, '0},
        '{10'd512,  10'd0,    1'b0, '0}
    };

    // DUT inputs, all known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [pwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [pwa_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic [23:0]                    i_s_tdata   = '0;  // voltage_sample, current_sample, pad
    logic                           i_m_tready  = 1'b0;

    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [3*pwa_pkg::ACC_W-1:0]    o_m_tdata;         // voltage_square_sum,
                                                       // current_square_sum, power_sum

    // model state: settings mirror plus the running window
    logic [pwa_pkg::SAMPLE_W-1:0] zero_ofs_m      = pwa_pkg::ZERO_OFFSET_RST;
    logic [pwa_pkg::GAIN_W-1:0]   v_gain_m        = pwa_pkg::GAIN_RST;
    logic [pwa_pkg::GAIN_W-1:0]   i_gain_m        = pwa_pkg::GAIN_RST;
    logic [9:0]                   pairs_in_window = '0;
    logic [pwa_pkg::ACC_W-1:0]    vsq_acc         = '0;
    logic [pwa_pkg::ACC_W-1:0]    isq_acc         = '0;
    logic [pwa_pkg::ACC_W-1:0]    pwr_acc         = '0;

    t_window_sums window_sums_q [$];   // sums still owed by the block
    int           mismatch_count = 0;
    bit           calm = 1'b0;         // no idling on either side

    power_window_accumulator #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // |code - offset| scaled by a Q8.8 gain, fraction truncated
    function automatic logic [pwa_pkg::OP_W-1:0] scaled_mag(
            input logic [pwa_pkg::SAMPLE_W-1:0] code,
            input logic [pwa_pkg::GAIN_W-1:0]   gain);
        logic [pwa_pkg::SAMPLE_W-1:0]                 mag;
        logic [pwa_pkg::SAMPLE_W+pwa_pkg::GAIN_W-1:0] prod;
        mag  = (code >= zero_ofs_m) ? code - zero_ofs_m : zero_ofs_m - code;
        prod = mag * gain;
        return prod[pwa_pkg::SAMPLE_W+pwa_pkg::GAIN_W-1:pwa_pkg::FRAC_W];
    endfunction

    function automatic logic [pwa_pkg::ACC_W-1:0] sat_add(
            input logic [pwa_pkg::ACC_W-1:0]  acc,
            input logic [pwa_pkg::PROD_W-1:0] add);
        logic [pwa_pkg::ACC_W:0] s;
        s = acc + add;
        return s[pwa_pkg::ACC_W] ? SUM_MAX : s[pwa_pkg::ACC_W-1:0];
    endfunction

    // One accepted pair into the window; done when the window closes.
    task automatic accumulate_pair(input  logic [pwa_pkg::SAMPLE_W-1:0] vs,
                                   input  logic [pwa_pkg::SAMPLE_W-1:0] cs,
                                   output bit                           done,
                                   output t_window_sums                 sums);
        logic [pwa_pkg::OP_W-1:0] v;
        logic [pwa_pkg::OP_W-1:0] i;
        v = scaled_mag(vs, v_gain_m);
        i = scaled_mag(cs, i_gain_m);
        vsq_acc = sat_add(vsq_acc, pwa_pkg::PROD_W'(v) * pwa_pkg::PROD_W'(v));
        isq_acc = sat_add(isq_acc, pwa_pkg::PROD_W'(i) * pwa_pkg::PROD_W'(i));
        pwr_acc = sat_add(pwr_acc, pwa_pkg::PROD_W'(v) * pwa_pkg::PROD_W'(i));
        pairs_in_window = pairs_in_window + 10'd1;
        done = (pairs_in_window == 0) || (pairs_in_window >= WINDOW);
        sums = '{pwr: pwr_acc, isq: isq_acc, vsq: vsq_acc};
        if (done) begin
            vsq_acc = '0;
            isq_acc = '0;
            pwr_acc = '0;
            pairs_in_window = '0;
        end
    endtask

    // Offer one pair, optionally after a random gap, and wait for acceptance.
    // A hand-typed expectation replaces the model's for that window.
    task automatic send_pair(input logic [pwa_pkg::SAMPLE_W-1:0] vs,
                             input logic [pwa_pkg::SAMPLE_W-1:0] cs,
                             input logic                         has_sums,
                             input t_window_sums                 typed_sums);
        bit           done;
        t_window_sums sums;
        if (!calm && $urandom_range(5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, cs, vs};
        do @(posedge i_clk); while (!o_s_tready);
        accumulate_pair(vs, cs, done, sums);
        if (done)
            window_sums_q.push_back(has_sums ? typed_sums : sums);
    endtask

    // Wait until every owed window has come out and the pipeline is empty.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (window_sums_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers and the spare index, back to back.
    task automatic configure(input logic [pwa_pkg::CFG_DATA_W-1:0] ofs_data,
                             input logic [pwa_pkg::CFG_DATA_W-1:0] v_gain,
                             input logic [pwa_pkg::CFG_DATA_W-1:0] i_gain);
        logic [pwa_pkg::CFG_IDX_W-1:0]  idx [4];
        logic [pwa_pkg::CFG_DATA_W-1:0] data [4];
        idx  = '{pwa_pkg::REG_ZERO_OFFSET, REG_SPARE,
                 pwa_pkg::REG_VOLTAGE_GAIN, pwa_pkg::REG_CURRENT_GAIN};
        data = '{ofs_data, pwa_pkg::CFG_DATA_W'($urandom), v_gain, i_gain};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[k];
            i_cfg_wdata <= data[k];
            @(posedge i_clk);
            case (idx[k])
                pwa_pkg::REG_ZERO_OFFSET:  zero_ofs_m = data[k][pwa_pkg::SAMPLE_W-1:0];
                pwa_pkg::REG_VOLTAGE_GAIN: v_gain_m   = data[k][pwa_pkg::GAIN_W-1:0];
                pwa_pkg::REG_CURRENT_GAIN: i_gain_m   = data[k][pwa_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Codes biased toward the rails and the current offset
    function automatic logic [pwa_pkg::SAMPLE_W-1:0] pick_code();
        case ($urandom_range(7))
            0:       return zero_ofs_m;
            1:       return '0;
            2:       return '1;
            default: return pwa_pkg::SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    // Result side back-pressure: random low bursts between ready stretches
    initial begin
        @(posedge i_clk);
        i_m_tready <= 1'b1;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(17, 1)) @(posedge i_clk);
                i_m_tready <= 1'b1;
                repeat ($urandom_range(40, 1)) @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(input string                     name,
                                        input logic [pwa_pkg::ACC_W-1:0] want,
                                        input logic [pwa_pkg::ACC_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result check: inputs and outputs are read as they stood before the edge
    always @(posedge i_clk) begin : result_check
        t_window_sums got;
        t_window_sums want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_window_sums'(o_m_tdata);
            if (window_sums_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = window_sums_q.pop_front();
                check_field("voltage_square_sum", want.vsq, got.vsq);
                check_field("current_square_sum", want.isq, got.isq);
                check_field("power_sum",          want.pwr, got.pwr);
            end
        end
    end

    initial begin : stimulus
        logic [pwa_pkg::SAMPLE_W-1:0]   ofs;
        logic [pwa_pkg::CFG_DATA_W-1:0] vg;
        logic [pwa_pkg::CFG_DATA_W-1:0] ig;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // offset written with its unused upper bits set: must land as 512
        configure(16'hFE00, pwa_pkg::GAIN_RST, pwa_pkg::GAIN_RST);
        for (int r = 0; r < DIRECTED_N; r++)
            send_pair(DIRECTED_ROWS[r].vs, DIRECTED_ROWS[r].cs,
                      DIRECTED_ROWS[r].has_sums, DIRECTED_ROWS[r].sums);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin            // largest magnitudes, full-scale gains
                    ofs = '0;   vg = '1;       ig = '1;
                end
                1: begin
                    ofs = '1;   vg = '0;       ig = '1;
                end
                2: begin
                    ofs = 10'd512; vg = '1;    ig = '0;
                end
                PHASES - 1: begin   // back to reset settings, no idling
                    ofs = pwa_pkg::ZERO_OFFSET_RST;
                    vg  = pwa_pkg::GAIN_RST;
                    ig  = pwa_pkg::GAIN_RST;
                end
                default: begin
                    ofs = pwa_pkg::SAMPLE_W'($urandom_range(1023));
                    vg  = pwa_pkg::CFG_DATA_W'($urandom);
                    ig  = pwa_pkg::CFG_DATA_W'($urandom);
                end
            endcase
            drain();
            // partial window carries over; only later pairs see new settings
            configure({6'($urandom_range(63)), ofs}, vg, ig);
            if (p == PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_ITEMS)
                send_pair(pick_code(), pick_code(), 1'b0, '0);
        end

        drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
